### rtl/gbr_pkg.sv
// Shared types, constants and font tables of the glyph bitmap rasterizer.
`timescale 1ns / 1ps
package gbr_pkg;

  localparam int MAX_GLYPHS_DEF = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [4:0] QMARK_INDEX = 5'd15;

  // One classified character, passed from the front end to the scanner.
  typedef struct packed {
    logic [2:0]  set;
    logic [4:0]  glyph;
    logic [2:0]  width;
    logic        vert;
    logic [15:0] base_x;
    logic [15:0] base_y;
  } gbr_job_t;

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_RUN  = 2'd1,
    SCAN_LAST = 2'd2
  } gbr_scan_state_t;

  // Glyph height of a font set.
  function automatic logic [3:0] glyph_height(input logic [2:0] set);
    case (set)
      3'd0:    glyph_height = 4'd5;
      3'd1:    glyph_height = 4'd6;
      3'd2:    glyph_height = 4'd7;
      default: glyph_height = 4'd8;
    endcase
  endfunction

  // Map an ASCII code to its glyph slot; anything unknown becomes '?'.
  function automatic logic [4:0] find_glyph(input logic [7:0] code);
    logic [4:0] g;
    g = QMARK_INDEX;
    if (code >= 8'h30 && code <= 8'h39) g = 5'(code - 8'h30);
    else begin
      case (code)
        8'h3A:   g = 5'd10;
        8'h41:   g = 5'd11;
        8'h50:   g = 5'd12;
        8'h2B:   g = 5'd13;
        8'h2D:   g = 5'd14;
        8'h20:   g = 5'd16;
        default: g = QMARK_INDEX;
      endcase
    end
    return g;
  endfunction

  // Glyph width in columns.
  function automatic logic [2:0] glyph_width(input logic [2:0] set, input logic [4:0] g);
    logic [2:0] w;
    if (g == 5'd10 || g == 5'd16) w = 3'd1;
    else if (set == 3'd4 && g != 5'd13 && g != 5'd14) w = 3'd4;
    else w = 3'd3;
    return w;
  endfunction

  // One font row; bits are right aligned, leftmost column at bit width-1.
  function automatic logic [3:0] glyph_row(input logic [2:0] set, input logic [4:0] g,
                                           input logic [2:0] r);
    logic [31:0] rows;
    rows = '0;
    case (set)
      3'd0: begin
        case (g)
          5'd0:  rows = 32'h00075557; 5'd1:  rows = 32'h00072262;
          5'd2:  rows = 32'h00074717; 5'd3:  rows = 32'h00071317;
          5'd4:  rows = 32'h00011755; 5'd5:  rows = 32'h00071747;
          5'd6:  rows = 32'h00075747; 5'd7:  rows = 32'h00022117;
          5'd8:  rows = 32'h00075757; 5'd9:  rows = 32'h00071757;
          5'd10: rows = 32'h00001010; 5'd11: rows = 32'h00055752;
          5'd12: rows = 32'h00044656; 5'd13: rows = 32'h00002720;
          5'd14: rows = 32'h00000700; 5'd15: rows = 32'h00020216;
          default: rows = '0;
        endcase
      end
      3'd1: begin
        case (g)
          5'd0:  rows = 32'h00755557; 5'd1:  rows = 32'h00722262;
          5'd2:  rows = 32'h00747117; 5'd3:  rows = 32'h00711317;
          5'd4:  rows = 32'h00117555; 5'd5:  rows = 32'h00711747;
          5'd6:  rows = 32'h00755747; 5'd7:  rows = 32'h00222117;
          5'd8:  rows = 32'h00755757; 5'd9:  rows = 32'h00717557;
          5'd10: rows = 32'h00010010; 5'd11: rows = 32'h00557552;
          5'd12: rows = 32'h00446556; 5'd13: rows = 32'h00002720;
          5'd14: rows = 32'h00000700; 5'd15: rows = 32'h00202116;
          default: rows = '0;
        endcase
      end
      3'd2: begin
        case (g)
          5'd0:  rows = 32'h07555557; 5'd1:  rows = 32'h07222262;
          5'd2:  rows = 32'h07447117; 5'd3:  rows = 32'h07113117;
          5'd4:  rows = 32'h01117555; 5'd5:  rows = 32'h07117447;
          5'd6:  rows = 32'h07557447; 5'd7:  rows = 32'h02221117;
          5'd8:  rows = 32'h07557557; 5'd9:  rows = 32'h07117557;
          5'd10: rows = 32'h00100010; 5'd11: rows = 32'h05557552;
          5'd12: rows = 32'h04446556; 5'd13: rows = 32'h00027200;
          5'd14: rows = 32'h00007000; 5'd15: rows = 32'h02022116;
          default: rows = '0;
        endcase
      end
      3'd3: begin
        case (g)
          5'd0:  rows = 32'h75555557; 5'd1:  rows = 32'h72222262;
          5'd2:  rows = 32'h74447117; 5'd3:  rows = 32'h71113117;
          5'd4:  rows = 32'h11117555; 5'd5:  rows = 32'h71117447;
          5'd6:  rows = 32'h75557447; 5'd7:  rows = 32'h22221117;
          5'd8:  rows = 32'h75557557; 5'd9:  rows = 32'h71117557;
          5'd10: rows = 32'h01000010; 5'd11: rows = 32'h55557552;
          5'd12: rows = 32'h44446556; 5'd13: rows = 32'h00027200;
          5'd14: rows = 32'h00007000; 5'd15: rows = 32'h20222116;
          default: rows = '0;
        endcase
      end
      default: begin
        case (g)
          5'd0:  rows = 32'hF999999F; 5'd1:  rows = 32'h72222262;
          5'd2:  rows = 32'hF888F11F; 5'd3:  rows = 32'hF111711F;
          5'd4:  rows = 32'h1111F999; 5'd5:  rows = 32'hF111F88F;
          5'd6:  rows = 32'hF999F88F; 5'd7:  rows = 32'h2222111F;
          5'd8:  rows = 32'hF999F99F; 5'd9:  rows = 32'hF111F99F;
          5'd10: rows = 32'h01000010; 5'd11: rows = 32'h9999F996;
          5'd12: rows = 32'h8888E99E; 5'd13: rows = 32'h00027200;
          5'd14: rows = 32'h00007000; 5'd15: rows = 32'h4044611E;
          default: rows = '0;
        endcase
      end
    endcase
    return rows[{r, 2'b00} +: 4];
  endfunction

endpackage

### rtl/gbr_front.sv
// Front end: label state, glyph lookup and placement base per character.
`timescale 1ns / 1ps
module gbr_front import gbr_pkg::*; #(
  parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  font_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_first_char,
  input  logic        in_orientation,
  input  logic [15:0] in_origin_x,
  input  logic [15:0] in_origin_y,
  input  logic [7:0]  in_label_width,
  output logic        job_valid,
  input  logic        job_ready,
  output gbr_job_t    job
);

  logic [7:0] advance_r, advance_nxt, adv_cur;
  logic [4:0] count_r, count_nxt, count_cur;
  logic [2:0] set;
  logic [4:0] g;
  logic [2:0] w;
  logic       take, drop;

  assign in_ready  = job_ready;
  assign take      = in_valid && in_ready;
  assign set       = (font_size > 3'd4) ? 3'd4 : font_size;
  assign g         = find_glyph(in_char_code);
  assign w         = glyph_width(set, g);
  assign adv_cur   = in_first_char ? 8'd0 : advance_r;
  assign count_cur = in_first_char ? 5'd0 : count_r;
  assign drop      = (count_cur >= 5'(MAX_GLYPHS));
  // Blank glyphs and characters past the limit never reach the scanner.
  assign job_valid = in_valid && !drop && (g != 5'd16);

  // Placement base: x/y of column zero, row zero.
  always_comb begin
    job.set   = set;
    job.glyph = g;
    job.width = w;
    job.vert  = in_orientation;
    if (in_orientation) begin
      job.base_x = in_origin_x;
      job.base_y = in_origin_y + {8'd0, in_label_width} - {8'd0, adv_cur} - 16'd1;
    end else begin
      job.base_x = in_origin_x + {8'd0, adv_cur};
      job.base_y = in_origin_y;
    end
  end

  // Advance and glyph count update on each accepted beat.
  always_comb begin
    advance_nxt = advance_r;
    count_nxt   = count_r;
    if (take) begin
      advance_nxt = adv_cur;
      count_nxt   = count_cur;
      if (!drop) begin
        advance_nxt = adv_cur + {5'd0, w} + 8'd1;
        count_nxt   = count_cur + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      advance_r <= '0;
      count_r   <= '0;
    end else begin
      advance_r <= advance_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule

### rtl/gbr_queue.sv
// Short job queue between the front end and the scanner.
`timescale 1ns / 1ps
module gbr_queue import gbr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  gbr_job_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output gbr_job_t rd_data
);

  gbr_job_t   mem_r [QUEUE_DEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/gbr_scan.sv
// Back end: scans a glyph bit by bit and emits one pixel beat per lit bit.
`timescale 1ns / 1ps
module gbr_scan import gbr_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  output logic            job_ready,
  input  gbr_job_t        job,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [15:0]     out_pixel_x,
  output logic [15:0]     out_pixel_y,
  output logic            out_last_pixel
);

  gbr_scan_state_t state_r, state_nxt;
  gbr_job_t   job_r, job_nxt;
  logic [2:0] row_r, row_nxt, col_r, col_nxt;
  logic       ov_r, ov_nxt;
  logic [15:0] px_r, px_nxt, py_r, py_nxt;
  logic       last_r, last_nxt;
  // A found pixel held back until the next lit one tells whether it is last.
  logic       hv_r, hv_nxt;
  logic [15:0] hx_r, hx_nxt, hy_r, hy_nxt;
  logic [3:0] rowbits;
  logic       bit_on, end_bit, out_free;
  logic [15:0] cx, cy;

  assign rowbits  = glyph_row(job_r.set, job_r.glyph, row_r);
  assign bit_on   = rowbits[2'(job_r.width - 3'd1 - col_r)];
  assign end_bit  = (col_r == job_r.width - 3'd1) &&
                    ({1'b0, row_r} == glyph_height(job_r.set) - 4'd1);
  assign cx = job_r.vert ? job_r.base_x + {13'd0, row_r} : job_r.base_x + {13'd0, col_r};
  assign cy = job_r.vert ? job_r.base_y - {13'd0, col_r} : job_r.base_y + {13'd0, row_r};
  assign out_free   = !ov_r || out_ready;
  assign job_ready  = (state_r == SCAN_IDLE);
  assign out_valid  = ov_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_last_pixel = last_r;

  // Sequencer: one font bit a cycle while the output register has room.
  always_comb begin
    state_nxt = state_r;
    job_nxt = job_r;
    row_nxt = row_r;
    col_nxt = col_r;
    ov_nxt  = ov_r && !out_ready;
    px_nxt = px_r; py_nxt = py_r; last_nxt = last_r;
    hv_nxt = hv_r; hx_nxt = hx_r; hy_nxt = hy_r;
    case (state_r)
      SCAN_IDLE: begin
        if (job_valid) begin
          job_nxt = job;
          row_nxt = '0;
          col_nxt = '0;
          hv_nxt  = 1'b0;
          state_nxt = SCAN_RUN;
        end
      end
      SCAN_RUN: begin
        if (out_free) begin
          if (bit_on && hv_r) begin
            ov_nxt = 1'b1; px_nxt = hx_r; py_nxt = hy_r; last_nxt = 1'b0;
          end
          if (bit_on) begin
            hv_nxt = 1'b1; hx_nxt = cx; hy_nxt = cy;
          end
          if (end_bit) begin
            state_nxt = SCAN_IDLE;
            hv_nxt = 1'b0;
            if (bit_on) begin
              ov_nxt = 1'b1; px_nxt = cx; py_nxt = cy; last_nxt = 1'b1;
              // Previously held pixel must go first; handled by the hold pass below.
            end else if (hv_r) begin
              ov_nxt = 1'b1; px_nxt = hx_r; py_nxt = hy_r; last_nxt = 1'b1;
            end
          end
          if (col_r == job_r.width - 3'd1) begin
            col_nxt = '0;
            row_nxt = row_r + 3'd1;
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
        // Final bit lit with a held pixel: emit the held one, then the final one from SCAN_LAST.
        if (out_free && end_bit && bit_on && hv_r) begin
          state_nxt = SCAN_LAST;
          ov_nxt = 1'b1; px_nxt = hx_r; py_nxt = hy_r; last_nxt = 1'b0;
          hv_nxt = 1'b1; hx_nxt = cx; hy_nxt = cy;
        end
      end
      SCAN_LAST: begin
        // The held final pixel goes out marked as last.
        if (out_free) begin
          ov_nxt = 1'b1; px_nxt = hx_r; py_nxt = hy_r; last_nxt = 1'b1;
          hv_nxt = 1'b0;
          state_nxt = SCAN_IDLE;
        end
      end
      default: state_nxt = SCAN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SCAN_IDLE;
      ov_r    <= 1'b0;
      hv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      hv_r    <= hv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt; row_r <= row_nxt; col_r <= col_nxt;
    px_r <= px_nxt; py_r <= py_nxt; last_r <= last_nxt;
    hx_r <= hx_nxt; hy_r <= hy_nxt;
  end

endmodule

### rtl/glyph_bitmap_rasterizer_unit.sv
// Top level of the glyph bitmap rasterizer.
`timescale 1ns / 1ps
// Character generator for a small clock font. Each input beat carries one
// character; the front end updates the label advance and glyph count and
// queues a job, and the scanner walks the glyph one font bit per clock
// while the output register has room, emitting one pixel beat per lit bit.
// For each character the scanner loads the job and scans width times height
// font bits; when its final font bit is lit, the held pixel goes out before
// the final one. Output stalls hold the scan. Blank and over-limit
// characters take no scanner time.
module glyph_bitmap_rasterizer_unit import gbr_pkg::*; #(
  parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_font_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        in_first_char,
  input  logic        in_orientation,
  input  logic signed [15:0] in_origin_x,
  input  logic signed [15:0] in_origin_y,
  input  logic [7:0]  in_label_width,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_pixel_x,
  output logic signed [15:0] out_pixel_y,
  output logic        out_last_pixel
);

  logic [2:0] font_size_r;
  logic       fj_valid, fj_ready, qj_valid, qj_ready;
  gbr_job_t   fj, qj;

  assign cfg_ready = 1'b1;

  // Font size register.
  always_ff @(posedge clk) begin
    if (!rst_n) font_size_r <= '0;
    else if (cfg_valid) font_size_r <= cfg_font_size;
  end

  gbr_front #(.MAX_GLYPHS(MAX_GLYPHS)) u_front (
    .clk, .rst_n, .font_size(font_size_r),
    .in_valid, .in_ready, .in_char_code, .in_first_char, .in_orientation,
    .in_origin_x, .in_origin_y, .in_label_width,
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  gbr_queue u_queue (
    .clk, .rst_n, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(qj_valid), .rd_ready(qj_ready), .rd_data(qj)
  );

  gbr_scan u_scan (
    .clk, .rst_n, .job_valid(qj_valid), .job_ready(qj_ready), .job(qj),
    .out_valid, .out_ready, .out_pixel_x, .out_pixel_y, .out_last_pixel
  );

endmodule
